[rtl/hpvt_pkg.sv]
// Package for the homogeneous point/vector transform block.
// Holds port widths and the configuration register indexes; no dependencies.
`timescale 1ns / 1ps

package hpvt_pkg;

	localparam int IO_W     = 32;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_COLS01 = 3'd0,
		REG_ROW0_COLS23 = 3'd1,
		REG_ROW1_COLS01 = 3'd2,
		REG_ROW1_COLS23 = 3'd3,
		REG_ROW2_COLS01 = 3'd4,
		REG_ROW2_COLS23 = 3'd5,
		REG_ROW3_COLS01 = 3'd6,
		REG_ROW3_COLS23 = 3'd7
	} cfg_reg_t;

endpackage

[rtl/hpvt_row_mac.sv]
// One matrix row times the input coordinate: three products and a sum.
// Two pipeline stages. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module hpvt_row_mac #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                      clk,
	input  logic signed [WORD_BITS-1:0]               c0,
	input  logic signed [WORD_BITS-1:0]               c1,
	input  logic signed [WORD_BITS-1:0]               c2,
	input  logic signed [WORD_BITS-1:0]               m0,
	input  logic signed [WORD_BITS-1:0]               m1,
	input  logic signed [WORD_BITS-1:0]               m2,
	input  logic signed [WORD_BITS-1:0]               m3,
	input  logic                                      add_t,
	output logic signed [2*WORD_BITS-FRAC_BITS+1:0]   sum
);

	localparam int PROD_W = 2 * WORD_BITS;
	localparam int SH_W   = PROD_W - FRAC_BITS;
	localparam int SUM_W  = SH_W + 2;

	logic signed [PROD_W-1:0]    pr0, pr1, pr2;
	logic signed [SH_W-1:0]      p0_s1, p1_s1, p2_s1;
	logic signed [WORD_BITS-1:0] t_s1;
	logic signed [SUM_W-1:0]     sum_s2;

	assign pr0 = PROD_W'(m0) * PROD_W'(c0);
	assign pr1 = PROD_W'(m1) * PROD_W'(c1);
	assign pr2 = PROD_W'(m2) * PROD_W'(c2);

	// Arithmetic right shift gives the round toward minus infinity.
	always_ff @(posedge clk) begin
		p0_s1 <= SH_W'(pr0 >>> FRAC_BITS);
		p1_s1 <= SH_W'(pr1 >>> FRAC_BITS);
		p2_s1 <= SH_W'(pr2 >>> FRAC_BITS);
		t_s1  <= add_t ? m3 : '0;
	end

	always_ff @(posedge clk) begin
		sum_s2 <= SUM_W'(p0_s1) + SUM_W'(p1_s1) + SUM_W'(p2_s1) + SUM_W'(t_s1);
	end

	assign sum = sum_s2;

endmodule

[rtl/hpvt_div_lane.sv]
// One output component: pipelined restoring divide by w, one quotient bit per
// stage, plus the vector clamp and the zero-w handling. No package needed.
`timescale 1ns / 1ps

module hpvt_div_lane #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic signed [2*WORD_BITS-FRAC_BITS+1:0] s,
	input  logic signed [2*WORD_BITS-FRAC_BITS+1:0] w,
	input  logic                                    point,
	output logic signed [WORD_BITS-1:0]             res,
	output logic                                    sat,
	output logic                                    wz
);

	localparam int SUM_W = 2 * WORD_BITS - FRAC_BITS + 2;
	localparam int R_W   = SUM_W + WORD_BITS + FRAC_BITS;
	localparam logic [WORD_BITS-1:0] WMAX_V = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WMIN_V = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic point;
		logic neg;
		logic wz;
		logic snz;
		logic sneg;
		logic ovf;
		logic vsat;
	} flags_t;

	logic [SUM_W-1:0]     mag_s, mag_w;
	logic                 vover;
	logic [R_W-1:0]       n_s1;
	logic [SUM_W-1:0]     d_s1;
	flags_t               flg_s1;
	flags_t               flg0;
	logic [WORD_BITS-1:0] vres_s1;

	logic [R_W-1:0]       rem_pipe  [0:WORD_BITS];
	logic [SUM_W-1:0]     den_pipe  [0:WORD_BITS];
	logic [WORD_BITS-1:0] quo_pipe  [0:WORD_BITS];
	logic [WORD_BITS-1:0] vres_pipe [0:WORD_BITS];
	flags_t               flg_pipe  [0:WORD_BITS];

	flags_t               f;
	logic [WORD_BITS-1:0] q;
	logic [WORD_BITS-1:0] res_v;

	assign mag_s = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
	assign mag_w = w[SUM_W-1] ? SUM_W'(-w) : SUM_W'(w);
	// The sum fits the word when all bits from the word's sign bit up agree.
	assign vover = !((&s[SUM_W-1:WORD_BITS-1]) || !(|s[SUM_W-1:WORD_BITS-1]));

	always_ff @(posedge clk) begin
		n_s1         <= R_W'(mag_s) << FRAC_BITS;
		d_s1         <= mag_w;
		flg_s1.point <= point;
		flg_s1.neg   <= s[SUM_W-1] ^ w[SUM_W-1];
		flg_s1.wz    <= (w == '0);
		flg_s1.snz   <= (s != '0);
		flg_s1.sneg  <= s[SUM_W-1];
		flg_s1.ovf   <= 1'b0;
		flg_s1.vsat  <= vover;
		vres_s1      <= vover ? (s[SUM_W-1] ? WMIN_V : WMAX_V) : s[WORD_BITS-1:0];
	end

	// A quotient of 2^WORD_BITS or more saturates whatever its sign.
	always_comb begin
		flg0     = flg_s1;
		flg0.ovf = n_s1 >= (R_W'(d_s1) << WORD_BITS);
	end

	always_ff @(posedge clk) begin
		rem_pipe[0]     <= n_s1;
		den_pipe[0]     <= d_s1;
		quo_pipe[0]     <= '0;
		vres_pipe[0]    <= vres_s1;
		flg_pipe[0]     <= flg0;
	end

	for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
		localparam int SH = WORD_BITS - 1 - k;
		logic [R_W-1:0] dsh;
		logic           ge;
		assign dsh = R_W'(den_pipe[k]) << SH;
		assign ge  = rem_pipe[k] >= dsh;
		always_ff @(posedge clk) begin
			rem_pipe[k+1]  <= ge ? rem_pipe[k] - dsh : rem_pipe[k];
			quo_pipe[k+1]  <= {quo_pipe[k][WORD_BITS-2:0], ge};
			den_pipe[k+1]  <= den_pipe[k];
			vres_pipe[k+1] <= vres_pipe[k];
			flg_pipe[k+1]  <= flg_pipe[k];
		end
	end

	assign f = flg_pipe[WORD_BITS];
	assign q = quo_pipe[WORD_BITS];

	always_comb begin
		res_v = q;
		sat   = 1'b0;
		if (!f.point) begin
			res_v = vres_pipe[WORD_BITS];
			sat   = f.vsat;
		end else if (f.wz) begin
			res_v = f.snz ? (f.sneg ? WMIN_V : WMAX_V) : '0;
			sat   = f.snz;
		end else if (f.ovf) begin
			res_v = f.neg ? WMIN_V : WMAX_V;
			sat   = 1'b1;
		end else if (!f.neg) begin
			if (q[WORD_BITS-1]) begin
				res_v = WMAX_V;
				sat   = 1'b1;
			end
		end else begin
			if (q > WMIN_V) begin
				res_v = WMIN_V;
				sat   = 1'b1;
			end else begin
				res_v = WORD_BITS'(-q);
			end
		end
	end

	assign res = res_v;
	assign wz  = f.point & f.wz;

endmodule

[rtl/homogeneous_point_vector_transform_top.sv]
// Top level of the 4x4 homogeneous point/vector transform in signed fixed point.
// Uses hpvt_pkg, hpvt_row_mac (four row lanes) and hpvt_div_lane (three lanes).
`timescale 1ns / 1ps

// Takes one item every clock; busy is never raised. Each result appears on
// out_valid after the input registers, the row multiply-add stages and the
// divider pipeline, and must be taken in that cycle. The divider resolves one
// quotient bit per pipeline stage in each of the three component lanes; four
// row lanes form the dot products in parallel. The matrix registers reset to
// identity and may be written only while no transaction is in flight.

module homogeneous_point_vector_transform_top
	import hpvt_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  logic signed [IO_W-1:0] in_x,
	input  logic signed [IO_W-1:0] in_y,
	input  logic signed [IO_W-1:0] in_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic                  out_valid,
	output logic signed [IO_W-1:0] out_x,
	output logic signed [IO_W-1:0] out_y,
	output logic signed [IO_W-1:0] out_z,
	output logic                  w_zero,
	output logic                  saturated
);

	localparam int SUM_W = 2 * WORD_BITS - FRAC_BITS + 2;
	localparam int VL    = WORD_BITS + 4;
	localparam logic [31:0] ONE_H = 32'(1) << FRAC_BITS;

	logic [CFG_W-1:0] cfg_q [0:7];

	logic                        valid_s1, point_s1, point_s2, point_s3;
	logic signed [WORD_BITS-1:0] cx_s1, cy_s1, cz_s1;
	logic [VL-1:0]               vld_q;

	logic signed [WORD_BITS-1:0] m   [0:3][0:3];
	logic signed [SUM_W-1:0]     sum [0:3];
	logic signed [WORD_BITS-1:0] res [0:2];
	logic                        sat [0:2];
	logic                        wz  [0:2];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_ROW0_COLS01] <= {32'd0, ONE_H};
			cfg_q[REG_ROW0_COLS23] <= '0;
			cfg_q[REG_ROW1_COLS01] <= {ONE_H, 32'd0};
			cfg_q[REG_ROW1_COLS23] <= '0;
			cfg_q[REG_ROW2_COLS01] <= '0;
			cfg_q[REG_ROW2_COLS23] <= {32'd0, ONE_H};
			cfg_q[REG_ROW3_COLS01] <= '0;
			cfg_q[REG_ROW3_COLS23] <= {ONE_H, 32'd0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW0_COLS01: cfg_q[REG_ROW0_COLS01] <= cfg_data;
				REG_ROW0_COLS23: cfg_q[REG_ROW0_COLS23] <= cfg_data;
				REG_ROW1_COLS01: cfg_q[REG_ROW1_COLS01] <= cfg_data;
				REG_ROW1_COLS23: cfg_q[REG_ROW1_COLS23] <= cfg_data;
				REG_ROW2_COLS01: cfg_q[REG_ROW2_COLS01] <= cfg_data;
				REG_ROW2_COLS23: cfg_q[REG_ROW2_COLS23] <= cfg_data;
				REG_ROW3_COLS01: cfg_q[REG_ROW3_COLS01] <= cfg_data;
				REG_ROW3_COLS23: cfg_q[REG_ROW3_COLS23] <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar r = 0; r < 4; r++) begin : g_ent
		assign m[r][0] = cfg_q[2*r][WORD_BITS-1:0];
		assign m[r][1] = cfg_q[2*r][32+WORD_BITS-1:32];
		assign m[r][2] = cfg_q[2*r+1][WORD_BITS-1:0];
		assign m[r][3] = cfg_q[2*r+1][32+WORD_BITS-1:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vld_q    <= '0;
		end else begin
			valid_s1 <= start && !busy;
			vld_q    <= {vld_q[VL-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		cx_s1    <= in_x[WORD_BITS-1:0];
		cy_s1    <= in_y[WORD_BITS-1:0];
		cz_s1    <= in_z[WORD_BITS-1:0];
		point_s1 <= !op;
		point_s2 <= point_s1;
		point_s3 <= point_s2;
	end

	// Rows 0..2 give the numerators, row 3 gives w (always with its last column).
	for (genvar r = 0; r < 4; r++) begin : g_row
		hpvt_row_mac #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mac (
			.clk   (clk),
			.c0    (cx_s1),
			.c1    (cy_s1),
			.c2    (cz_s1),
			.m0    (m[r][0]),
			.m1    (m[r][1]),
			.m2    (m[r][2]),
			.m3    (m[r][3]),
			.add_t ((r == 3) ? 1'b1 : point_s1),
			.sum   (sum[r])
		);
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		hpvt_div_lane #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
			.clk   (clk),
			.s     (sum[k]),
			.w     (sum[3]),
			.point (point_s3),
			.res   (res[k]),
			.sat   (sat[k]),
			.wz    (wz[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			w_zero    <= 1'b0;
			saturated <= 1'b0;
		end else begin
			out_valid <= vld_q[VL-1];
			w_zero    <= vld_q[VL-1] & wz[0];
			saturated <= vld_q[VL-1] & (sat[0] | sat[1] | sat[2]);
		end
	end

	always_ff @(posedge clk) begin
		out_x <= IO_W'(res[0]);
		out_y <= IO_W'(res[1]);
		out_z <= IO_W'(res[2]);
	end

endmodule

[rtl/hpvt_checker.sv]
// Port-level checks for the transform top level, attached by bind.
// Depends on hpvt_pkg and on homogeneous_point_vector_transform_top.
`timescale 1ns / 1ps

module hpvt_checker
	import hpvt_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   cfg_ready,
	input logic                   out_valid,
	input logic signed [IO_W-1:0] out_x,
	input logic signed [IO_W-1:0] out_y,
	input logic signed [IO_W-1:0] out_z,
	input logic                   w_zero,
	input logic                   saturated
);

	localparam int LAT = WORD_BITS + 6;

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("block stalled an input or configuration transaction");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(start && !busy, LAT))
		else $error("result without a matching start transaction");

	a_wzero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && w_zero) |-> (saturated == (out_x != 0 || out_y != 0 || out_z != 0)))
		else $error("zero-w result inconsistent with saturated flag");

	a_flags_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> (!w_zero && !saturated))
		else $error("flags raised without a result");

endmodule

bind homogeneous_point_vector_transform_top hpvt_checker #(.WORD_BITS(WORD_BITS)) u_hpvt_chk (.*);
